/* hdl/deq_pkg.sv */
// Shared constants, codes and types for the bounded deque and its storage cells.
package deq_pkg;

	// Number of storage cells and the width of one entry.
	localparam int DEPTH  = 16;
	localparam int ITEM_W = 32;

	// Widths that follow from the depth.
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int PHASE_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;

	// Field widths on the ports.
	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int LEN_W    = 5;
	localparam int STATUS_W = 2;

	// Operation codes carried by a request.
	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_COUNT      = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DELETE     = 3'd5;

	// Result status codes.
	localparam logic [STATUS_W-1:0] RS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] RS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] RS_EMPTY = 2'd2;

	// Commands broadcast to every cell of the chain.
	localparam int CMD_W = 4;
	localparam logic [CMD_W-1:0] CC_HOLD       = 4'd0;
	localparam logic [CMD_W-1:0] CC_PUSH_FRONT = 4'd1;
	localparam logic [CMD_W-1:0] CC_PUSH_BACK  = 4'd2;
	localparam logic [CMD_W-1:0] CC_POP_FRONT  = 4'd3;
	localparam logic [CMD_W-1:0] CC_POP_BACK   = 4'd4;
	localparam logic [CMD_W-1:0] CC_MARK       = 4'd5;
	localparam logic [CMD_W-1:0] CC_SWAP       = 4'd6;
	localparam logic [CMD_W-1:0] CC_SETTLE     = 4'd7;
	localparam logic [CMD_W-1:0] CC_UNMARK     = 4'd8;

	// Control broadcast to all cells.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             phase_odd;
	} cell_ctl_t;

	// What one cell shows to its neighbours.
	typedef struct packed {
		logic [ITEM_W-1:0] value;
		logic              valid;
		logic              hole;
	} cell_link_t;

endpackage

/* hdl/deq_cell.sv */
// One storage cell of the deque chain: an entry, its valid flag and its delete mark.
module deq_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  deq_pkg::cell_ctl_t         ctl,
	input  logic [deq_pkg::ITEM_W-1:0] target,
	input  logic                       odd_slot,
	input  deq_pkg::cell_link_t        left_in,
	input  deq_pkg::cell_link_t        right_in,
	output deq_pkg::cell_link_t        link_out
);
	import deq_pkg::*;

	logic [ITEM_W-1:0] value_q;
	logic              valid_q;
	logic              hole_q;
	logic [ITEM_W-1:0] value_n;
	logic              valid_n;
	logic              hole_n;
	logic              gap;
	logic              left_gap;
	logic              right_gap;
	logic              right_side;

	// A gap is a slot that the compaction may fill: empty or marked for removal.
	assign gap        = hole_q | ~valid_q;
	assign left_gap   = left_in.hole | ~left_in.valid;
	assign right_gap  = right_in.hole | ~right_in.valid;
	assign right_side = odd_slot ^ ctl.phase_odd;

	always_comb begin
		value_n = value_q;
		valid_n = valid_q;
		hole_n  = hole_q;
		case (ctl.cmd)
			CC_PUSH_FRONT: begin
				value_n = left_in.value;
				valid_n = left_in.valid;
				hole_n  = 1'b0;
			end
			CC_PUSH_BACK: begin
				if (!valid_q && left_in.valid) begin
					value_n = target;
					valid_n = 1'b1;
				end
			end
			CC_POP_FRONT: begin
				value_n = right_in.value;
				valid_n = right_in.valid;
				hole_n  = 1'b0;
			end
			CC_POP_BACK: begin
				if (valid_q && !right_in.valid) begin
					valid_n = 1'b0;
				end
			end
			CC_MARK: begin
				hole_n = valid_q & (value_q == target);
			end
			CC_SWAP: begin
				if (!right_side && gap && !right_gap) begin
					value_n = right_in.value;
					valid_n = right_in.valid;
					hole_n  = right_in.hole;
				end else if (right_side && left_gap && !gap) begin
					value_n = left_in.value;
					valid_n = left_in.valid;
					hole_n  = left_in.hole;
				end
			end
			CC_SETTLE: begin
				valid_n = valid_q & ~hole_q;
				hole_n  = 1'b0;
			end
			CC_UNMARK: begin
				hole_n = 1'b0;
			end
			default: begin
				value_n = value_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hole_q  <= 1'b0;
		end else begin
			valid_q <= valid_n;
			hole_q  <= hole_n;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_n;
	end

	assign link_out.value = value_q;
	assign link_out.valid = valid_q;
	assign link_out.hole  = hole_q;

endmodule

/* hdl/bounded_deque_with_match_removal_top.sv */
// Top level of the bounded deque with count and order-keeping delete of matching entries.
//
// The deque holds up to DEPTH entries (16 by default) in a chain of identical cells, cell 0
// being the front. Every request on the input channel yields exactly one result carrying the
// new length, the front and back entries (zero when empty), the match count and a status.
// A push, a pop or an unused operation code shifts or updates the cells on the edge that
// accepts the request; the result register is then loaded from the report state once the
// output register is free. For count and delete the cells mark their matches on the accepting
// edge, then DEPTH phases of odd-even transposition move marked and empty slots towards the
// back one neighbour at a time, while a shift register tallies the marks one per cycle; the
// settle state then drops the marked entries and the report state loads the result. Count
// runs the same sequence without moving anything. The block takes one request at a
// time: in_stall is high from acceptance until the result has been placed in the output
// register, but a result left waiting under out_stall does not hold off the next request.
// A push when full or a pop when empty leaves the deque unchanged and reports the refusal.
module bounded_deque_with_match_removal_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [deq_pkg::FUNC_W-1:0]   func,
	input  logic [deq_pkg::VALUE_W-1:0]  item_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [deq_pkg::LEN_W-1:0]    list_length,
	output logic [deq_pkg::VALUE_W-1:0]  front_value,
	output logic [deq_pkg::VALUE_W-1:0]  back_value,
	output logic [deq_pkg::LEN_W-1:0]    match_count,
	output logic [deq_pkg::STATUS_W-1:0] status
);
	import deq_pkg::*;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SORT   = 2'd1;
	localparam logic [1:0] ST_SETTLE = 2'd2;
	localparam logic [1:0] ST_REPORT = 2'd3;

	logic [1:0]          state_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    match_q;
	logic [DEPTH-1:0]    flags_q;
	logic [STATUS_W-1:0] status_q;
	logic                is_del_q;

	logic                out_valid_q;
	logic [LEN_W-1:0]    out_len_q;
	logic [VALUE_W-1:0]  out_front_q;
	logic [VALUE_W-1:0]  out_back_q;
	logic [LEN_W-1:0]    out_match_q;
	logic [STATUS_W-1:0] out_status_q;

	logic                take;
	logic                full;
	logic                empty;
	logic                load_out;
	logic [ITEM_W-1:0]   target;
	cell_ctl_t           ctl;
	cell_link_t          links [DEPTH];
	cell_link_t          head_link;
	cell_link_t          tail_link;
	logic [DEPTH-1:0]    valid_vec;
	logic [DEPTH-1:0]    hole_vec;
	logic [DEPTH-1:0]    last_vec;
	logic [ITEM_W-1:0]   back_entry;
	logic [DEPTH:0]      valid_run;

	assign in_stall = (state_q != ST_IDLE);
	assign take     = in_valid & ~in_stall;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign target   = item_value[ITEM_W-1:0];

	// The front cell sees the pushed value as its left neighbour; the back cell sees
	// an empty slot to its right.
	assign head_link.value = target;
	assign head_link.valid = 1'b1;
	assign head_link.hole  = 1'b0;
	assign tail_link.value = '0;
	assign tail_link.valid = 1'b0;
	assign tail_link.hole  = 1'b0;

	// Command broadcast to the cells, one per cycle.
	always_comb begin
		ctl.cmd       = CC_HOLD;
		ctl.phase_odd = phase_q[0];
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (func)
						FN_PUSH_FRONT: ctl.cmd = full  ? CC_HOLD : CC_PUSH_FRONT;
						FN_PUSH_BACK:  ctl.cmd = full  ? CC_HOLD : CC_PUSH_BACK;
						FN_POP_FRONT:  ctl.cmd = empty ? CC_HOLD : CC_POP_FRONT;
						FN_POP_BACK:   ctl.cmd = empty ? CC_HOLD : CC_POP_BACK;
						FN_COUNT:      ctl.cmd = CC_MARK;
						FN_DELETE:     ctl.cmd = CC_MARK;
						default:       ctl.cmd = CC_HOLD;
					endcase
				end
			end
			ST_SORT:   ctl.cmd = is_del_q ? CC_SWAP : CC_HOLD;
			ST_SETTLE: ctl.cmd = is_del_q ? CC_SETTLE : CC_UNMARK;
			default:   ctl.cmd = CC_HOLD;
		endcase
	end

	// The chain of cells.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cells
		cell_link_t left_l;
		cell_link_t right_l;
		if (i == 0) begin : g_head
			assign left_l = head_link;
		end else begin : g_mid_l
			assign left_l = links[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_l = tail_link;
		end else begin : g_mid_r
			assign right_l = links[i+1];
		end
		deq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.target   (target),
			.odd_slot (1'(i % 2)),
			.left_in  (left_l),
			.right_in (right_l),
			.link_out (links[i])
		);
		assign valid_vec[i] = links[i].valid;
		assign hole_vec[i]  = links[i].hole;
	end

	// The back entry is the one valid cell whose right neighbour is empty.
	assign last_vec = valid_vec & ~({1'b0, valid_vec[DEPTH-1:1]});

	always_comb begin
		back_entry = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_entry = back_entry | ({ITEM_W{last_vec[i]}} & links[i].value);
		end
	end

	// Adding one to the valid mask gives a power of two exactly when the entries are packed.
	assign valid_run = {1'b0, valid_vec} + (DEPTH+1)'(1);

	assign load_out = (state_q == ST_REPORT) && (!out_valid_q || !out_stall);

	// Sequencer, entry count and match tally.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= '0;
			count_q  <= '0;
			match_q  <= '0;
			flags_q  <= '0;
			status_q <= RS_DONE;
			is_del_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						match_q  <= '0;
						phase_q  <= '0;
						is_del_q <= (func == FN_DELETE);
						case (func)
							FN_PUSH_FRONT, FN_PUSH_BACK: begin
								state_q <= ST_REPORT;
								if (full) begin
									status_q <= RS_FULL;
								end else begin
									status_q <= RS_DONE;
									count_q  <= count_q + CNT_W'(1);
								end
							end
							FN_POP_FRONT, FN_POP_BACK: begin
								state_q <= ST_REPORT;
								if (empty) begin
									status_q <= RS_EMPTY;
								end else begin
									status_q <= RS_DONE;
									count_q  <= count_q - CNT_W'(1);
								end
							end
							FN_COUNT, FN_DELETE: begin
								state_q  <= ST_SORT;
								status_q <= RS_DONE;
							end
							default: begin
								state_q  <= ST_REPORT;
								status_q <= RS_DONE;
							end
						endcase
					end
				end
				ST_SORT: begin
					// The marks are copied out before the first exchange and counted
					// one per cycle while the cells compact.
					if (phase_q == '0) begin
						flags_q <= hole_vec >> 1;
						match_q <= CNT_W'(hole_vec[0]);
					end else begin
						flags_q <= flags_q >> 1;
						match_q <= match_q + CNT_W'(flags_q[0]);
					end
					phase_q <= phase_q + PHASE_W'(1);
					if (phase_q == PHASE_W'(DEPTH - 1)) begin
						state_q <= ST_SETTLE;
					end
				end
				ST_SETTLE: begin
					if (is_del_q) begin
						count_q <= count_q - match_q;
					end
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: holds a finished result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_len_q    <= LEN_W'(count_q);
			out_front_q  <= links[0].valid ? VALUE_W'(links[0].value) : '0;
			out_back_q   <= VALUE_W'(back_entry);
			out_match_q  <= LEN_W'(match_q);
			out_status_q <= status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign list_length = out_len_q;
	assign front_value = out_front_q;
	assign back_value  = out_back_q;
	assign match_count = out_match_q;
	assign status      = out_status_q;

	// The number of occupied cells always agrees with the entry count.
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("occupied cells disagree with entry count");

	// Entries are packed from the front whenever a result is reported.
	a_packed_at_report: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT) |-> $onehot(valid_run))
		else $error("entries not packed from the front");

	// No removal mark survives past the end of a count or delete.
	a_no_marks_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (hole_vec == '0))
		else $error("removal mark left behind");

	// A result appears only after the report state.
	a_result_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_REPORT))
		else $error("result loaded outside the report state");

endmodule
